// File: rtl/rkp_pkg.sv
// ----------------------------------------------------------------------------
// rkp_pkg
// Shared types and constants for the RSA key pair core and its units.
// ----------------------------------------------------------------------------
package rkp_pkg;

   // Port width of each prime factor request field
   localparam int FACTOR_PORT_BITS = 16;

   // Width of each result exponent / modulus field
   localparam int RESULT_BITS = 32;

   // Status returned by an iterative arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// File: rtl/rkp_divu.sv
// ----------------------------------------------------------------------------
// rkp_divu
// Restoring divider, one quotient bit per cycle. Gives quotient and remainder.
// ----------------------------------------------------------------------------
module rkp_divu
   import rkp_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output unit_status_type  status,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;

   // one shift / compare / subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in    = trial - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign status    = '{busy: busy_ff, done: done_ff};
   assign quotient  = quo_ff;
   assign remainder = rem_ff[WIDTH-1:0];

endmodule

// File: rtl/rkp_mulu.sv
// ----------------------------------------------------------------------------
// rkp_mulu
// Shift-add multiplier, one multiplier bit per cycle, low WIDTH bits kept.
// ----------------------------------------------------------------------------
module rkp_mulu
   import rkp_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output unit_status_type  status,
   output logic [WIDTH-1:0] product
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] mca_ff, mca_in;
   logic [WIDTH-1:0] mpb_ff, mpb_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // one add-and-shift step
   always_comb begin
      acc_in  = acc_ff;
      mca_in  = mca_ff;
      mpb_in  = mpb_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mca_in  = op_a;
         mpb_in  = op_b;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mpb_ff[0]) begin
            acc_in = acc_ff + mca_ff;
         end
         mca_in = {mca_ff[WIDTH-2:0], 1'b0};
         mpb_in = {1'b0, mpb_ff[WIDTH-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mca_ff <= mca_in;
      mpb_ff <= mpb_in;
      cnt_ff <= cnt_in;
   end

   assign status  = '{busy: busy_ff, done: done_ff};
   assign product = acc_ff;

endmodule

// File: rtl/rsa_key_pair_from_primes_core.sv
// ----------------------------------------------------------------------------
// rsa_key_pair_from_primes_core
// Textbook RSA key pair (e, d, n) from two given prime factors.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_factor_p / req_factor_q and pulse start while busy is low; the
//   request is taken at that edge and busy rises on the next cycle.
//   Factor bits above FACTOR_WIDTH are ignored.
//   One result appears for exactly one cycle with rsp_valid high: public
//   exponent e, private exponent d, modulus n and an error flag. The error
//   flag is set, all other fields zero, when p, q or phi = (p-1)(q-1) is below 2.
//   The receiver cannot stall; the result must be taken when rsp_valid is high.
// Sequence:
//   Data dependent. With PW = 2*min(FACTOR_WIDTH,16): two PW-bit products,
//   an integer square root, a Euclid gcd per trial exponent and an extended
//   Euclid for the inverse, on the serial divider and multiplier that are
//   shared across the steps. One request at a time.
// Reset:
//   Synchronous, active high; returns the sequencer to idle, drops any work.
// ----------------------------------------------------------------------------
module rsa_key_pair_from_primes_core
   import rkp_pkg::*;
#(
   parameter int FACTOR_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [FACTOR_PORT_BITS-1:0] req_factor_p,
   input  logic [FACTOR_PORT_BITS-1:0] req_factor_q,
   output logic                        rsp_valid,
   output logic [RESULT_BITS-1:0]      rsp_public_exponent,
   output logic [RESULT_BITS-1:0]      rsp_private_exponent,
   output logic [RESULT_BITS-1:0]      rsp_modulus,
   output logic                        rsp_error
);

   localparam int EFW = (FACTOR_WIDTH < FACTOR_PORT_BITS) ? FACTOR_WIDTH : FACTOR_PORT_BITS;
   localparam int PW  = 2 * EFW;
   localparam int SCW = $clog2(PW / 2 + 1);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PHI_GO,
      ST_PHI_WAIT,
      ST_N_GO,
      ST_N_WAIT,
      ST_SQRT,
      ST_GCD_INIT,
      ST_GCD_CHK,
      ST_GCD_WAIT,
      ST_INV_INIT,
      ST_INV_CHK,
      ST_INV_DIV_WAIT,
      ST_INV_MUL_GO,
      ST_INV_MUL_WAIT,
      ST_FIN,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [EFW-1:0]   p_ff, q_ff;
   logic [PW-1:0]    phi_ff, n_ff;
   logic [PW-1:0]    x_ff, res_ff, bit_ff;
   logic [SCW-1:0]   cnt_ff;
   logic [PW-1:0]    e_ff;
   logic [PW-1:0]    ga_ff, gb_ff;
   logic [PW-1:0]    u_ff, v_ff, ca_ff, cb_ff, quo_ff, rem_ff;
   logic             aneg_ff, bneg_ff;
   logic             err_ff;
   logic [PW-1:0]    d_ff;

   logic             div_start, mul_start;
   logic [PW-1:0]    div_a, div_b, mul_a, mul_b;
   unit_status_type  div_st, mul_st;
   logic [PW-1:0]    div_q, div_r, mul_p;
   logic [PW:0]      sq_sum;
   logic [PW-1:0]    a_red;

   // shared arithmetic units
   rkp_divu #(.WIDTH(PW)) u_divu (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b),
      .status(div_st), .quotient(div_q), .remainder(div_r)
   );

   rkp_mulu #(.WIDTH(PW)) u_mulu (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(mul_a), .op_b(mul_b),
      .status(mul_st), .product(mul_p)
   );

   // operand selection for the shared units
   always_comb begin
      mul_start = 1'b0;
      mul_a     = PW'(p_ff);
      mul_b     = PW'(q_ff);
      div_start = 1'b0;
      div_a     = ga_ff;
      div_b     = gb_ff;
      unique case (state_ff)
         ST_PHI_GO: begin
            mul_start = 1'b1;
            mul_a     = PW'(p_ff) - 1'b1;
            mul_b     = PW'(q_ff) - 1'b1;
         end
         ST_N_GO: begin
            mul_start = 1'b1;
         end
         ST_GCD_CHK: begin
            div_start = (gb_ff != '0);
         end
         ST_INV_CHK: begin
            div_start = (v_ff != '0);
            div_a     = u_ff;
            div_b     = v_ff;
         end
         ST_INV_MUL_GO: begin
            mul_start = 1'b1;
            mul_a     = quo_ff;
            mul_b     = cb_ff;
         end
         default: begin
         end
      endcase
   end

   // square root step sum and final coefficient reduction
   assign sq_sum = {1'b0, res_ff} + {1'b0, bit_ff};
   assign a_red  = (ca_ff >= phi_ff) ? (ca_ff - phi_ff) : ca_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  p_ff <= req_factor_p[EFW-1:0];
                  q_ff <= req_factor_q[EFW-1:0];
                  if (req_factor_p[EFW-1:0] < EFW'(2) || req_factor_q[EFW-1:0] < EFW'(2)) begin
                     err_ff   <= 1'b1;
                     state_ff <= ST_DONE;
                  end else begin
                     err_ff   <= 1'b0;
                     state_ff <= ST_PHI_GO;
                  end
               end
            end
            ST_PHI_GO: state_ff <= ST_PHI_WAIT;
            ST_PHI_WAIT: begin
               if (mul_st.done) begin
                  phi_ff   <= mul_p;
                  state_ff <= ST_N_GO;
               end
            end
            ST_N_GO: state_ff <= ST_N_WAIT;
            ST_N_WAIT: begin
               if (mul_st.done) begin
                  n_ff   <= mul_p;
                  x_ff   <= phi_ff;
                  res_ff <= '0;
                  bit_ff <= PW'(1) << (PW - 2);
                  cnt_ff <= SCW'(PW / 2);
                  if (phi_ff < PW'(2)) begin
                     err_ff   <= 1'b1;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_SQRT;
                  end
               end
            end
            // one digit pair of the integer square root per cycle
            ST_SQRT: begin
               if ({1'b0, x_ff} >= sq_sum) begin
                  x_ff   <= x_ff - sq_sum[PW-1:0];
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == SCW'(1)) begin
                  state_ff <= ST_GCD_INIT;
               end
               e_ff <= res_ff;
            end
            ST_GCD_INIT: begin
               if (cnt_ff == '0 && bit_ff == '0) begin
                  e_ff <= res_ff;
                  ga_ff <= res_ff;
               end else begin
                  ga_ff <= e_ff;
               end
               cnt_ff   <= SCW'(1);
               gb_ff    <= phi_ff;
               state_ff <= ST_GCD_CHK;
            end
            ST_GCD_CHK: begin
               if (gb_ff == '0) begin
                  if (ga_ff == PW'(1)) begin
                     state_ff <= ST_INV_INIT;
                  end else begin
                     e_ff     <= e_ff + 1'b1;
                     ga_ff    <= e_ff + 1'b1;
                     gb_ff    <= phi_ff;
                  end
               end else begin
                  state_ff <= ST_GCD_WAIT;
               end
            end
            ST_GCD_WAIT: begin
               if (div_st.done) begin
                  ga_ff    <= gb_ff;
                  gb_ff    <= div_r;
                  state_ff <= ST_GCD_CHK;
               end
            end
            ST_INV_INIT: begin
               u_ff     <= phi_ff;
               v_ff     <= e_ff;
               ca_ff    <= '0;
               cb_ff    <= PW'(1);
               aneg_ff  <= 1'b0;
               bneg_ff  <= 1'b0;
               state_ff <= ST_INV_CHK;
            end
            ST_INV_CHK: begin
               if (v_ff == '0) begin
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_INV_DIV_WAIT;
               end
            end
            ST_INV_DIV_WAIT: begin
               if (div_st.done) begin
                  quo_ff   <= div_q;
                  rem_ff   <= div_r;
                  state_ff <= ST_INV_MUL_GO;
               end
            end
            ST_INV_MUL_GO: state_ff <= ST_INV_MUL_WAIT;
            ST_INV_MUL_WAIT: begin
               if (mul_st.done) begin
                  cb_ff    <= ca_ff + mul_p;
                  ca_ff    <= cb_ff;
                  aneg_ff  <= bneg_ff;
                  bneg_ff  <= !bneg_ff;
                  u_ff     <= v_ff;
                  v_ff     <= rem_ff;
                  state_ff <= ST_INV_CHK;
               end
            end
            ST_FIN: begin
               if (aneg_ff && a_red != '0) begin
                  d_ff <= phi_ff - a_red;
               end else begin
                  d_ff <= a_red;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_valid <= 1'b1;
               state_ff  <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result fields, zero on error
   assign rsp_public_exponent  = err_ff ? '0 : RESULT_BITS'(e_ff);
   assign rsp_private_exponent = err_ff ? '0 : RESULT_BITS'(d_ff);
   assign rsp_modulus          = err_ff ? '0 : RESULT_BITS'(n_ff);
   assign rsp_error            = err_ff;
   assign busy                 = (state_ff != ST_IDLE);

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rsa_key_pair_from_primes_core: a directed table of
// factor pairs, then random pairs, each result compared with a typed-in key or a key predictor.
// ----------------------------------------------------------------------------
module tb
   import rkp_pkg::*;
;

   localparam int FW = 16;
   localparam int NUM_RANDOM = 300;

   typedef struct packed {
      logic [RESULT_BITS-1:0] pub_exp;
      logic [RESULT_BITS-1:0] priv_exp;
      logic [RESULT_BITS-1:0] modulus;
      logic                   err;
   } key_pair_type;

   typedef struct {
      logic [FACTOR_PORT_BITS-1:0] p;
      logic [FACTOR_PORT_BITS-1:0] q;
      bit                          typed;
      key_pair_type                key;
   } key_row_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [FACTOR_PORT_BITS-1:0] req_factor_p;
   logic [FACTOR_PORT_BITS-1:0] req_factor_q;
   logic                        rsp_valid;
   logic [RESULT_BITS-1:0]      rsp_public_exponent;
   logic [RESULT_BITS-1:0]      rsp_private_exponent;
   logic [RESULT_BITS-1:0]      rsp_modulus;
   logic                        rsp_error;

   key_pair_type  pending_keys[$];
   key_row_type   key_table[$];
   int            error_count = 0;
   int            key_count = 0;
   int            fault_count = 0;
   bit            row_typed;
   key_pair_type  row_key;

   rsa_key_pair_from_primes_core #(.FACTOR_WIDTH(FW)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_factor_p(req_factor_p), .req_factor_q(req_factor_q),
      .rsp_valid(rsp_valid), .rsp_public_exponent(rsp_public_exponent),
      .rsp_private_exponent(rsp_private_exponent), .rsp_modulus(rsp_modulus),
      .rsp_error(rsp_error)
   );

   // Clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Safety net
   initial begin
      #(4 * 40_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [63:0] isqrt64(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Extended Euclid, tracking coefficient magnitudes and alternating signs
   function automatic logic [63:0] inverse64(logic [63:0] e, logic [63:0] m);
      logic [63:0] u, v, a, b, qt, r, nb;
      bit          a_neg, b_neg;
      u = m; v = e % m; a = 0; b = 1; a_neg = 0; b_neg = 0;
      while (v != 0) begin
         qt = u / v;
         r = u - qt * v;
         nb = a + qt * b;
         a = b; a_neg = b_neg;
         b = nb; b_neg = !b_neg;
         u = v; v = r;
      end
      a = a % m;
      if (a_neg && a != 0) return m - a;
      return a;
   endfunction

   function automatic key_pair_type predict_key(logic [FACTOR_PORT_BITS-1:0] fp,
                                                logic [FACTOR_PORT_BITS-1:0] fq);
      logic [63:0]  p, q, phi, e, d;
      key_pair_type k;
      p = 64'(fp) & ((64'd1 << FW) - 1);
      q = 64'(fq) & ((64'd1 << FW) - 1);
      k = '0;
      k.err = 1'b1;
      if (p < 2 || q < 2) return k;
      phi = (p - 1) * (q - 1);
      if (phi < 2) return k;
      e = isqrt64(phi);
      while (gcd64(e, phi) != 1) e++;
      d = inverse64(e, phi);
      k.pub_exp = e[31:0];
      k.priv_exp = d[31:0];
      k.modulus = 32'(p * q);
      k.err = 1'b0;
      return k;
   endfunction

   function automatic key_pair_type err_key();
      key_pair_type k;
      k = '0;
      k.err = 1'b1;
      return k;
   endfunction

   function automatic key_pair_type good_key(int e, int d, int n);
      key_pair_type k;
      k.pub_exp = e; k.priv_exp = d; k.modulus = n; k.err = 1'b0;
      return k;
   endfunction

   // Record each accepted request, with the expected key unless typed in
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         pending_keys.push_back(row_typed ? row_key : predict_key(req_factor_p, req_factor_q));
      end
   end

   // Compare each result with the oldest expected key
   always @(posedge clock) begin
      key_pair_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_public_exponent, rsp_private_exponent, rsp_modulus, rsp_error};
         key_count++;
         if (got.err) fault_count++;
         if (pending_keys.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result e=%0d d=%0d n=%0d err=%0b", $time,
                     got.pub_exp, got.priv_exp, got.modulus, got.err);
         end else begin
            want = pending_keys.pop_front();
            if (got.pub_exp !== want.pub_exp) begin
               error_count++;
               $display("%0t: public exponent exp %0d got %0d", $time, want.pub_exp, got.pub_exp);
            end
            if (got.priv_exp !== want.priv_exp) begin
               error_count++;
               $display("%0t: private exponent exp %0d got %0d", $time, want.priv_exp,
                        got.priv_exp);
            end
            if (got.modulus !== want.modulus) begin
               error_count++;
               $display("%0t: modulus exp %0d got %0d", $time, want.modulus, got.modulus);
            end
            if (got.err !== want.err) begin
               error_count++;
               $display("%0t: error flag exp %0b got %0b", $time, want.err, got.err);
            end
         end
      end
   end

   // Present one request and hold it until the core takes it
   task automatic send_request(logic [FACTOR_PORT_BITS-1:0] fp, logic [FACTOR_PORT_BITS-1:0] fq,
                               bit typed, key_pair_type k, bit may_idle);
      while (may_idle && $urandom_range(99) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_factor_p <= fp;
      req_factor_q <= fq;
      row_typed <= typed;
      row_key <= k;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   function automatic logic [FACTOR_PORT_BITS-1:0] random_factor();
      int sel;
      sel = $urandom_range(99);
      if (sel < 8) return FACTOR_PORT_BITS'($urandom_range(3));
      if (sel < 40) return FACTOR_PORT_BITS'($urandom_range(255));
      return FACTOR_PORT_BITS'($urandom);
   endfunction

   // Stimulus
   initial begin
      key_row_type row;
      int          wait_cycles;
      reset = 1; start = 0; req_factor_p = 0; req_factor_q = 0;
      row_typed = 0; row_key = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Zero, one and two-by-two factors give the error flag; a few small
      // pairs read at a glance; the rest from the predictor
      key_table = '{
         '{16'd0, 16'd0, 1, err_key()},
         '{16'd0, 16'hFFFF, 1, err_key()},
         '{16'hFFFF, 16'd0, 1, err_key()},
         '{16'd1, 16'd1, 1, err_key()},
         '{16'd1, 16'hFFFF, 1, err_key()},
         '{16'hFFFF, 16'd1, 1, err_key()},
         '{16'd2, 16'd2, 1, err_key()},
         '{16'd2, 16'd3, 1, good_key(1, 1, 6)},
         '{16'd3, 16'd2, 1, good_key(1, 1, 6)},
         '{16'd3, 16'd3, 1, good_key(3, 3, 9)},
         '{16'd2, 16'hFFFF, 0, '0},
         '{16'hFFFF, 16'd2, 0, '0},
         '{16'hFFFF, 16'hFFFF, 0, '0},
         '{16'd61, 16'd53, 0, '0},
         '{16'd65521, 16'd65519, 0, '0},
         '{16'h8000, 16'h7FFF, 0, '0},
         '{16'h5555, 16'hAAAA, 0, '0},
         '{16'd4, 16'd5, 0, '0}
      };
      foreach (key_table[i]) begin
         row = key_table[i];
         send_request(row.p, row.q, row.typed, row.key, 1'b1);
      end

      // Random pairs; the middle third runs back to back
      for (int i = 0; i < NUM_RANDOM; i++) begin
         send_request(random_factor(), random_factor(), 1'b0, '0,
                      !(i >= 100 && i < 200));
      end
      start <= 1'b0;

      // Drain
      wait_cycles = 0;
      while (pending_keys.size() != 0 && wait_cycles < 2_000_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (64) @(posedge clock);
      $display("Checked %0d key results (%0d with error flag) from %0d requests.",
               key_count, fault_count, key_table.size() + NUM_RANDOM);
      if (error_count == 0 && pending_keys.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (pending_keys.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, pending_keys.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
